// ----- sv/ssefd_pkg.sv -----
`default_nettype none

package ssefd_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 64;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  localparam logic [7:0] TYPE_VALUE = 8'h01;
  localparam logic [7:0] TYPE_TEXT  = 8'h04;
  localparam logic [7:0] FMT_VALUE  = 8'h00;

  typedef enum logic [2:0] {
    KIND_VALUE  = 3'd0,
    KIND_TEXT   = 3'd1,
    KIND_BADTYP = 3'd2,
    KIND_BADFMT = 3'd3,
    KIND_LONG   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TYPE,
    ST_FORMAT,
    ST_LEN_H,
    ST_LEN_L,
    ST_START,
    ST_DATA,
    ST_END,
    ST_FOOTER,
    ST_READ,
    ST_SEND
  } state_t;

endpackage

`default_nettype wire

// ----- sv/soh_stx_etx_frame_deframer.sv -----
`default_nettype none

// Channel  Dir  Bits  Contents
// s_*      in   8     tdata: rx_byte
// m_*      out  24    tdata: out_byte, frame_type, frame_format; tuser: kind; tlast: last
//
// Each header, delimiter and payload byte is accepted while parsing.
// The footer byte starts draining the payload store: each result is read from the store
// into the output register (ST_READ), then transferred (ST_SEND), until the store is empty.
// Error and too-long results take one transfer. s_tready is low while results drain;
// m_tready low holds the current result. rst is synchronous and returns to idle.

module soh_stx_etx_frame_deframer
  import ssefd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_byte, [15:8] frame_type, [23:16] frame_format
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  state_t         state;
  state_t         state_next;
  logic [7:0]     held_type;
  logic [7:0]     held_format;
  logic [15:0]    declared_length;
  logic [CW-1:0]  bytes_stored;
  logic [CW-1:0]  remaining;
  logic [AW-1:0]  rd_addr;
  logic           reverse;
  logic [7:0]     out_byte;
  kind_t          kind;
  logic           last;
  logic [7:0]     payload_store [PAYLOAD_DEPTH];

  logic           s_xfer;
  logic           m_xfer;
  logic [7:0]     rx_byte;
  logic [15:0]    full_length;
  logic [CW-1:0]  bytes_inc;
  logic           too_long;

  assign rx_byte     = s_tdata;
  assign s_xfer      = s_tvalid && s_tready;
  assign m_xfer      = m_tvalid && m_tready;
  assign full_length = {declared_length[15:8], rx_byte};
  assign too_long    = full_length > 16'(PAYLOAD_DEPTH);
  assign bytes_inc   = bytes_stored + CW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_xfer && rx_byte == SOH_BYTE) state_next = ST_TYPE;
      ST_TYPE:   if (s_xfer) state_next = ST_FORMAT;
      ST_FORMAT: if (s_xfer) state_next = ST_LEN_H;
      ST_LEN_H:  if (s_xfer) state_next = ST_LEN_L;
      ST_LEN_L: begin
        if (s_xfer) state_next = too_long ? ST_SEND : ST_START;
      end
      ST_START: begin
        if (s_xfer) state_next = (rx_byte == STX_BYTE) ? ST_DATA : ST_IDLE;
      end
      ST_DATA: begin
        if (s_xfer) begin
          if (declared_length == 16'd0) begin
            state_next = ST_IDLE;
          end else if (16'(bytes_inc) == declared_length) begin
            state_next = ST_END;
          end
        end
      end
      ST_END: begin
        if (s_xfer) state_next = (rx_byte == ETX_BYTE) ? ST_FOOTER : ST_IDLE;
      end
      ST_FOOTER: begin
        if (s_xfer) begin
          if ((held_type == TYPE_VALUE && held_format == FMT_VALUE) ||
              held_type == TYPE_TEXT) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_SEND;
          end
        end
      end
      ST_READ: state_next = ST_SEND;
      ST_SEND: begin
        if (m_xfer) state_next = (remaining == '0) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b1;
    m_tvalid = 1'b0;
    unique case (state)
      ST_READ: s_tready = 1'b0;
      ST_SEND: begin
        s_tready = 1'b0;
        m_tvalid = 1'b1;
      end
      default: s_tready = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      held_type       <= '0;
      held_format     <= '0;
      declared_length <= '0;
      bytes_stored    <= '0;
      remaining       <= '0;
    end else begin
      state <= state_next;
      if (state_next == ST_IDLE) begin
        held_type       <= '0;
        held_format     <= '0;
        declared_length <= '0;
        bytes_stored    <= '0;
      end
      if (s_xfer) begin
        unique case (state)
          ST_TYPE:   held_type <= rx_byte;
          ST_FORMAT: held_format <= rx_byte;
          ST_LEN_H:  declared_length <= {rx_byte, 8'h00};
          ST_LEN_L: begin
            declared_length <= full_length;
            remaining       <= '0;
          end
          ST_DATA: begin
            if (declared_length != 16'd0) bytes_stored <= bytes_inc;
          end
          ST_FOOTER: remaining <= (state_next == ST_READ) ? bytes_stored : '0;
          default: remaining <= remaining;
        endcase
      end
      if (state == ST_READ) remaining <= remaining - CW'(1);
    end
  end

  // load output register and drive the drain address
  always_ff @(posedge clk) begin
    if (s_xfer && state == ST_LEN_L) begin
      out_byte <= '0;
      kind     <= KIND_LONG;
      last     <= 1'b1;
    end
    if (s_xfer && state == ST_FOOTER) begin
      out_byte <= '0;
      last     <= 1'b1;
      reverse  <= held_type == TYPE_VALUE;
      if (held_type == TYPE_VALUE) begin
        kind    <= (held_format == FMT_VALUE) ? KIND_VALUE : KIND_BADFMT;
        rd_addr <= AW'(bytes_stored - CW'(1));
      end else if (held_type == TYPE_TEXT) begin
        kind    <= KIND_TEXT;
        rd_addr <= '0;
      end else begin
        kind    <= KIND_BADTYP;
      end
    end
    if (state == ST_READ) begin
      out_byte <= payload_store[rd_addr];
      last     <= remaining == CW'(1);
      rd_addr  <= reverse ? rd_addr - AW'(1) : rd_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer && state == ST_DATA && declared_length != 16'd0) begin
      payload_store[AW'(bytes_stored)] <= rx_byte;
    end
  end

  assign m_tdata = {held_format, held_type, out_byte};
  assign m_tuser = kind;
  assign m_tlast = last;

endmodule

`default_nettype wire
